// ===== design/sbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types and codes for the session binding table.
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int ENTRIES_DEF = 16;

    // operation codes
    localparam logic [2:0] K_BIND   = 3'd0;
    localparam logic [2:0] K_UNBIND = 3'd1;
    localparam logic [2:0] K_LOOKUP = 3'd2;
    localparam logic [2:0] K_TOUCH  = 3'd3;
    localparam logic [2:0] K_EXPIRE = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] channel_tag;
        logic [31:0] thread_tag;
        logic [63:0] agent;
        logic [31:0] idle_timeout;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] agent_out;
        logic [8:0]  expired_count;
    } t_rsp;

    // one stored binding
    typedef struct packed {
        logic [31:0] channel;
        logic [31:0] thread;
        logic [63:0] agent;
        logic [31:0] last_seen;
        logic [31:0] timeout;
    } t_rec;

endpackage

// ===== design/sbt_rec_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_rec_ram
// Binding record store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbt_rec_ram #(
    parameter int ENTRIES = sbt_pkg::ENTRIES_DEF,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  sbt_pkg::t_rec i_wdata,
    input  logic [AW-1:0] i_raddr,
    output sbt_pkg::t_rec o_rdata
);
    import sbt_pkg::*;

    t_rec r_mem [ENTRIES];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/session_binding_table_with_idle_aging_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_binding_table_with_idle_aging_top
// Key-matched binding table with idle-timeout aging, scanned out of a RAM.
// ----------------------------------------------------------------------------
// The scan reads each slot in turn, checks the last read word, then commits
//   in S_DONE; busy drops only once the result is registered, and the result
//   is taken at the edge that ends the o_strobe cycle.
// A new command is accepted only while busy is low: transactions never overlap.
// The receiver cannot stall: o_strobe is high for one cycle per result, and
//   o_rsp holds the result until the next one is registered.
// Reset (synchronous, active low) clears all valid bits and the control state;
//   the record RAM is not cleared and needs no clearing pass.
module session_binding_table_with_idle_aging_top #(
    parameter int ENTRIES = sbt_pkg::ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sbt_pkg::t_cmd i_cmd,
    output logic          o_strobe,
    output sbt_pkg::t_rsp o_rsp
);
    import sbt_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state;
    t_cmd               r_cmd;
    logic [CW-1:0]      r_addr;     // next RAM address to read, ENTRIES = done
    logic               r_chk;      // RAM read data valid this cycle
    logic [AW-1:0]      r_chk_idx;  // slot that read data belongs to
    logic               r_hit;
    logic [AW-1:0]      r_hit_idx;
    t_rec               r_hit_rec;
    logic               r_free;
    logic [AW-1:0]      r_free_idx;
    logic [8:0]         r_count;
    logic [ENTRIES-1:0] r_valid;
    logic               r_strobe;
    t_rsp               r_rsp;

    logic          accept;
    logic          scan_more;
    t_rec          rd_rec;
    logic          cur_valid;
    logic          key_match;
    logic          aged;
    logic [31:0]   idle_time;
    logic          we;
    logic [AW-1:0] waddr;
    t_rec          wdata;
    t_rsp          n_rsp;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign scan_more = (r_addr < CW'(ENTRIES));

    // ---------------------------------------------------------------------
    // Record RAM: read one slot per scan cycle, write on bind/touch commit
    // ---------------------------------------------------------------------
    sbt_rec_ram #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rd_rec)
    );

    // ---------------------------------------------------------------------
    // Per-slot evaluation of the word returned by the RAM
    // ---------------------------------------------------------------------
    assign cur_valid = r_valid[r_chk_idx];
    assign key_match = cur_valid &&
                       (rd_rec.channel == r_cmd.channel_tag) &&
                       (rd_rec.thread  == r_cmd.thread_tag);
    // last_seen <= now is checked first, so the difference never wraps
    assign idle_time = r_cmd.now - rd_rec.last_seen;
    assign aged      = cur_valid && (rd_rec.timeout != 32'd0) &&
                       (rd_rec.last_seen <= r_cmd.now) &&
                       (idle_time >= rd_rec.timeout);

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chk   <= 1'b0;
        end else begin
            r_chk <= (r_state == S_SCAN) && scan_more;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!scan_more) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // scan bookkeeping: first key match, first free slot, aged count
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_addr  <= '0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_count <= '0;
        end else if (r_state == S_SCAN) begin
            if (scan_more) begin
                r_addr <= r_addr + CW'(1);
            end
            if (r_chk) begin
                if (key_match && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_chk_idx;
                    r_hit_rec <= rd_rec;
                end
                if (!cur_valid && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_chk_idx;
                end
                if ((r_cmd.kind == K_EXPIRE) && aged) begin
                    r_count <= r_count + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_addr[AW-1:0];
    end

    // ---------------------------------------------------------------------
    // Commit: RAM write and response for the finished scan
    // ---------------------------------------------------------------------
    always_comb begin
        we    = 1'b0;
        waddr = r_hit_idx;
        wdata = r_hit_rec;
        n_rsp = '{status: ST_OK, agent_out: 64'd0, expired_count: 9'd0};
        unique case (r_cmd.kind)
            K_BIND: begin
                waddr = r_free_idx;
                wdata = '{channel:   r_cmd.channel_tag,
                          thread:    r_cmd.thread_tag,
                          agent:     r_cmd.agent,
                          last_seen: r_cmd.now,
                          timeout:   r_cmd.idle_timeout};
                if (r_hit) begin
                    n_rsp.status = ST_DUP;
                end else if (r_free) begin
                    we = 1'b1;
                end else begin
                    n_rsp.status = ST_FULL;
                end
            end
            K_UNBIND: begin
                if (!r_hit) begin
                    n_rsp.status = ST_NOTFOUND;
                end
            end
            K_LOOKUP: begin
                if (r_hit) begin
                    n_rsp.agent_out = r_hit_rec.agent;
                end else begin
                    n_rsp.status = ST_NOTFOUND;
                end
            end
            K_TOUCH: begin
                wdata.last_seen = r_cmd.now;
                if (r_hit) begin
                    we = 1'b1;
                end else begin
                    n_rsp.status = ST_NOTFOUND;
                end
            end
            K_EXPIRE: begin
                n_rsp.expired_count = r_count;
            end
            default: begin
            end
        endcase
        if (r_state != S_DONE) begin
            we = 1'b0;
        end
    end

    // valid bits: aged slots drop during the scan, bind/unbind at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (r_state == S_SCAN) begin
            if (r_chk && (r_cmd.kind == K_EXPIRE) && aged) begin
                r_valid[r_chk_idx] <= 1'b0;
            end
        end else if (r_state == S_DONE) begin
            if ((r_cmd.kind == K_BIND) && we) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if ((r_cmd.kind == K_UNBIND) && r_hit) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    // result register: one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
